[rtl/core/wmrm_pkg.sv]
// shared types, codes and constants of the windowed message rate monitor
`timescale 1ns / 1ps
package wmrm_pkg;

  // default ring depth
  localparam int unsigned DEF_SAMPLE_DEPTH = 256;

  // field widths
  localparam int unsigned TS_W       = 63;
  localparam int unsigned BYTES_W    = 32;
  localparam int unsigned LAT_W      = 32;
  localparam int unsigned ENTRY_W    = TS_W + BYTES_W + LAT_W;
  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned OUT_DATA_W = 408;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_W      = 16;

  // register reset values and substitutes
  localparam logic [CFG_W-1:0] WINDOW_RST      = 16'd1000;
  localparam logic [CFG_W-1:0] WINDOW_ZERO_SUB = 16'd100;
  localparam logic [CFG_W-1:0] FACTOR_RST      = 16'd512;
  localparam logic [CFG_W-1:0] FACTOR_MIN      = 16'd256;

  // arithmetic constants
  localparam logic [63:0] NS_Q8     = 64'd256000000000;
  localparam logic [63:0] NS_PER_S  = 64'd1000000000;
  localparam logic [35:0] NS_PER_MS = 36'd1000000;
  localparam logic [63:0] MS_PER_S  = 64'd1000;

  // request kinds
  typedef enum logic [OP_W-1:0] {
    OP_ARRIVE = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  // configuration register indexes
  typedef enum logic {
    CFG_WINDOW = 1'b0,
    CFG_FACTOR = 1'b1
  } cfg_idx_e;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ARRIVE,
    CMD_CLEAR,
    CMD_PRUNE_READ,
    CMD_PRUNE_TEST,
    CMD_WALK_START,
    CMD_WALK_READ,
    CMD_WALK_ACC,
    CMD_ARITH_START,
    CMD_ARITH_STORE,
    CMD_OUT
  } cmd_e;

  // arithmetic steps of a query, in order
  typedef enum logic [3:0] {
    SEL_AVG_MUL,
    SEL_AVG_DIV,
    SEL_RMIN_DIV,
    SEL_RMAX_DIV,
    SEL_BW_MUL,
    SEL_BW_DIV,
    SEL_LAVG_DIV,
    SEL_DROP_L,
    SEL_DROP_R
  } sel_e;

  typedef struct packed {
    cmd_e cmd;
    sel_e sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ring_empty;
    logic prune_old;
    logic walk_last;
    logic arith_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

[rtl/core/wmrm_ram.sv]
// generic single write, single registered read port memory
`timescale 1ns / 1ps
module wmrm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/wmrm_arith.sv]
// shared multi-cycle unit: 64x32 digit-serial multiply, 64/64 restoring divide
`timescale 1ns / 1ps
module wmrm_arith (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        div_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [95:0] result_o
);

  localparam logic [5:0] DIV_LAST = 6'd63;
  localparam logic [5:0] MUL_LAST = 6'd3;

  logic        busy_q, done_q, div_q;
  logic [5:0]  step_q;
  logic [95:0] acc_q, acc_d;
  logic [63:0] opnd_q, quo_q, rem_q, rem_d;
  logic [31:0] mplier_q;
  logic [64:0] trial, diff;
  logic [71:0] pp;
  logic        ge;

  // one multiplier digit or one quotient bit per cycle
  always_comb begin
    pp    = opnd_q * mplier_q[31:24];
    acc_d = {acc_q[87:0], 8'h00} + {24'h000000, pp};
    trial = {rem_q, quo_q[63]};
    ge    = trial >= {1'b0, opnd_q};
    diff  = trial - {1'b0, opnd_q};
    rem_d = ge ? diff[63:0] : trial[63:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      div_q  <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        div_q  <= div_i;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 6'd1;
        if (step_q == (div_q ? DIV_LAST : MUL_LAST)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands and partial results
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      opnd_q   <= div_i ? b_i : a_i;
      quo_q    <= a_i;
      mplier_q <= b_i[31:0];
      rem_q    <= '0;
      acc_q    <= '0;
    end else if (busy_q) begin
      if (div_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[62:0], ge};
      end else begin
        acc_q    <= acc_d;
        mplier_q <= {mplier_q[23:0], 8'h00};
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = div_q ? {32'h00000000, quo_q} : acc_q;

endmodule

[rtl/core/wmrm_dp.sv]
// datapath: ring store, totals, window walk, arithmetic and result register
`timescale 1ns / 1ps
module wmrm_dp #(
  parameter int unsigned SAMPLE_DEPTH = wmrm_pkg::DEF_SAMPLE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_addr_i,
  input  logic [15:0]           cfg_data_i,
  input  logic [62:0]           in_ts_i,
  input  logic [31:0]           in_bytes_i,
  input  logic [31:0]           in_lat_i,
  input  wmrm_pkg::ctrl_cmd_t   cmd_i,
  output wmrm_pkg::ctrl_sts_t   sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [407:0]          out_data_o
);
  import wmrm_pkg::*;

  localparam int unsigned AW     = $clog2(SAMPLE_DEPTH);
  localparam int unsigned CW     = $clog2(SAMPLE_DEPTH + 1);
  localparam int unsigned SW     = CW + 1;
  localparam int unsigned BSUM_W = BYTES_W + CW;
  localparam int unsigned LSUM_W = 31 + CW;
  localparam logic [CW-1:0] DEPTH_C = CW'(SAMPLE_DEPTH);

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(SAMPLE_DEPTH)) s = s - SW'(SAMPLE_DEPTH);
    return s[AW-1:0];
  endfunction

  // configuration and state
  logic [15:0]       window_q, factor_q;
  logic [AW-1:0]     head_q;
  logic [CW-1:0]     count_q, k_q;
  logic [62:0]       prev_ts_q, gap_q;
  logic              prev_valid_q;
  logic [47:0]       msgs_q;
  logic [55:0]       btot_q;
  logic              out_valid_q;

  // latched request and query work registers
  logic [62:0]       ts_q;
  logic [31:0]       bytes_q, lat_q;
  logic [35:0]       win_ns_q;
  logic [15:0]       wms_q, fac_q;
  logic [62:0]       first_q, last_q, pts_q, gmin_q, gmax_q;
  logic [BSUM_W-1:0] bsum_q;
  logic [LSUM_W-1:0] lsum_q;
  logic [CW-1:0]     lcnt_q;
  logic [30:0]       lmin_q, lmax_q;
  logic [63:0]       tmp_q, avg_q, rmin_q, rmax_q, bw_q, lavg_q;
  logic [95:0]       prodl_q, prodr_q;
  logic [407:0]      out_data_q;

  // combinational helpers
  logic [ENTRY_W-1:0] rd_data;
  logic [62:0]        rd_ts, span, wgap;
  logic [31:0]        rd_bytes, rd_lat;
  logic [30:0]        rd_l;
  logic [AW-1:0]      rd_addr, wr_addr, head_inc;
  logic               full, we, lat_ok;
  logic [56:0]        btot_sum;
  logic [CW-1:0]      nm1;
  logic               n_one, n_two, span_pos;
  logic [15:0]        wms_eff, fac_eff;
  logic [63:0]        ar_a, ar_b;
  logic               ar_div, ar_done;
  logic [95:0]        ar_res;
  logic [407:0]       out_build;
  logic               drop;

  // ring addressing and entry fields
  always_comb begin
    head_inc = wrap_add(head_q, CW'(1));
    full     = count_q == DEPTH_C;
    wr_addr  = full ? head_q : wrap_add(head_q, count_q);
    rd_addr  = wrap_add(head_q, (cmd_i.cmd == CMD_PRUNE_READ) ? '0 : k_q);
    we       = cmd_i.cmd == CMD_ARRIVE;
    rd_ts    = rd_data[62:0];
    rd_bytes = rd_data[94:63];
    rd_lat   = rd_data[126:95];
    rd_l     = rd_lat[30:0];
    lat_ok   = !rd_lat[31];
    wgap     = (rd_ts > pts_q) ? rd_ts - pts_q : '0;
    btot_sum = {1'b0, btot_q} + 57'(bytes_q);
    wms_eff  = (window_q == '0) ? WINDOW_ZERO_SUB : window_q;
    fac_eff  = (factor_q > FACTOR_MIN) ? factor_q : FACTOR_RST;
    nm1      = count_q - CW'(1);
    n_one    = count_q == CW'(1);
    n_two    = count_q >= CW'(2);
    span_pos = last_q > first_q;
    span     = span_pos ? last_q - first_q : '0;
  end

  wmrm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SAMPLE_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wr_addr),
    .wdata_i({lat_q, bytes_q, ts_q}),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // operand selection for the shared unit
  always_comb begin
    ar_a   = '0;
    ar_b   = '0;
    ar_div = 1'b0;
    case (cmd_i.sel)
      SEL_AVG_MUL:  begin ar_a = NS_Q8;          ar_b = 64'(nm1);                  end
      SEL_AVG_DIV:  begin ar_a = tmp_q;          ar_b = 64'(span);    ar_div = 1'b1; end
      SEL_RMIN_DIV: begin ar_a = NS_Q8;          ar_b = 64'(gmax_q);  ar_div = 1'b1; end
      SEL_RMAX_DIV: begin ar_a = NS_Q8;          ar_b = 64'(gmin_q);  ar_div = 1'b1; end
      SEL_BW_MUL:   begin ar_a = 64'(bsum_q);    ar_b = MS_PER_S;                  end
      SEL_BW_DIV:   begin ar_a = tmp_q;          ar_b = 64'(wms_q);   ar_div = 1'b1; end
      SEL_LAVG_DIV: begin ar_a = 64'(lsum_q);    ar_b = 64'(lcnt_q);  ar_div = 1'b1; end
      SEL_DROP_L:   begin
        ar_a = 64'(gap_q);
        ar_b = n_one ? 64'd1 : 64'(nm1);
      end
      SEL_DROP_R:   begin
        ar_a = n_one ? NS_PER_S : 64'(span);
        ar_b = 64'(fac_q);
      end
      default: ;
    endcase
  end

  wmrm_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cmd == CMD_ARITH_START),
    .div_i   (ar_div),
    .a_i     (ar_a),
    .b_i     (ar_b),
    .done_o  (ar_done),
    .result_o(ar_res)
  );

  // result assembly
  always_comb begin
    drop = (gap_q != '0) && (n_one || (n_two && span_pos)) &&
           ({prodl_q, 8'h00} > {8'h00, prodr_q});
    out_build = '0;
    out_build[31:0]    = n_one ? 32'd256 :
                         (n_two && span_pos) ? ((|avg_q[63:32]) ? '1 : avg_q[31:0]) : '0;
    out_build[63:32]   = n_one ? 32'd256 :
                         (n_two && gmax_q != '0) ? ((|rmin_q[63:32]) ? '1 : rmin_q[31:0]) : '0;
    out_build[95:64]   = n_one ? 32'd256 :
                         (n_two && gmax_q != '0) ? ((|rmax_q[63:32]) ? '1 : rmax_q[31:0]) : '0;
    out_build[143:96]  = (count_q == '0) ? '0 : ((|bw_q[63:48]) ? '1 : bw_q[47:0]);
    out_build[175:144] = (lcnt_q != '0) ? lavg_q[31:0] : '1;
    out_build[207:176] = (lcnt_q != '0) ? {1'b0, lmin_q} : '1;
    out_build[239:208] = (lcnt_q != '0) ? {1'b0, lmax_q} : '1;
    out_build[287:240] = msgs_q;
    out_build[343:288] = btot_q;
    out_build[344]     = drop;
    out_build[407:345] = gap_q;
  end

  // state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q     <= WINDOW_RST;
      factor_q     <= FACTOR_RST;
      head_q       <= '0;
      count_q      <= '0;
      k_q          <= '0;
      prev_ts_q    <= '0;
      prev_valid_q <= 1'b0;
      gap_q        <= '0;
      msgs_q       <= '0;
      btot_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_WINDOW: window_q <= cfg_data_i;
          CFG_FACTOR: factor_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.cmd)
        CMD_ARRIVE: begin
          gap_q        <= (prev_valid_q && ts_q > prev_ts_q) ? ts_q - prev_ts_q : '0;
          head_q       <= full ? head_inc : head_q;
          count_q      <= full ? count_q : count_q + CW'(1);
          prev_ts_q    <= ts_q;
          prev_valid_q <= 1'b1;
          if (msgs_q != '1) msgs_q <= msgs_q + 48'd1;
          btot_q       <= btot_sum[56] ? '1 : btot_sum[55:0];
        end
        CMD_CLEAR: begin
          head_q       <= '0;
          count_q      <= '0;
          prev_ts_q    <= '0;
          prev_valid_q <= 1'b0;
          gap_q        <= '0;
          msgs_q       <= '0;
          btot_q       <= '0;
        end
        CMD_PRUNE_TEST: begin
          if (sts_o.prune_old) begin
            head_q  <= head_inc;
            count_q <= count_q - CW'(1);
          end
        end
        CMD_WALK_START: k_q <= '0;
        CMD_WALK_ACC:   k_q <= k_q + CW'(1);
        CMD_OUT:        out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // work registers without reset
  always_ff @(posedge clk_i) begin
    case (cmd_i.cmd)
      CMD_LOAD: begin
        ts_q     <= in_ts_i;
        bytes_q  <= in_bytes_i;
        lat_q    <= in_lat_i;
        wms_q    <= wms_eff;
        fac_q    <= fac_eff;
        win_ns_q <= 36'(wms_eff) * NS_PER_MS;
      end
      CMD_WALK_START: begin
        first_q <= '0;
        last_q  <= '0;
        gmin_q  <= '0;
        gmax_q  <= '0;
        bsum_q  <= '0;
        lsum_q  <= '0;
        lcnt_q  <= '0;
        lmin_q  <= '0;
        lmax_q  <= '0;
      end
      CMD_WALK_ACC: begin
        if (k_q == '0) begin
          first_q <= rd_ts;
        end else if (wgap != '0) begin
          if (gmin_q == '0 || wgap < gmin_q) gmin_q <= wgap;
          if (wgap > gmax_q) gmax_q <= wgap;
        end
        pts_q  <= rd_ts;
        last_q <= rd_ts;
        bsum_q <= bsum_q + BSUM_W'(rd_bytes);
        if (lat_ok) begin
          if (lcnt_q == '0 || rd_l < lmin_q) lmin_q <= rd_l;
          if (lcnt_q == '0 || rd_l > lmax_q) lmax_q <= rd_l;
          lsum_q <= lsum_q + LSUM_W'(rd_l);
          lcnt_q <= lcnt_q + CW'(1);
        end
      end
      CMD_ARITH_STORE: begin
        case (cmd_i.sel)
          SEL_AVG_MUL:  tmp_q   <= ar_res[63:0];
          SEL_AVG_DIV:  avg_q   <= ar_res[63:0];
          SEL_RMIN_DIV: rmin_q  <= ar_res[63:0];
          SEL_RMAX_DIV: rmax_q  <= ar_res[63:0];
          SEL_BW_MUL:   tmp_q   <= ar_res[63:0];
          SEL_BW_DIV:   bw_q    <= ar_res[63:0];
          SEL_LAVG_DIV: lavg_q  <= ar_res[63:0];
          SEL_DROP_L:   prodl_q <= ar_res;
          SEL_DROP_R:   prodr_q <= ar_res;
          default: ;
        endcase
      end
      CMD_OUT: out_data_q <= out_build;
      default: ;
    endcase
  end

  // status to the controller
  always_comb begin
    sts_o.ring_empty = count_q == '0;
    sts_o.prune_old  = (64'(rd_ts) + 64'(win_ns_q)) < 64'(ts_q);
    sts_o.walk_last  = k_q == nm1;
    sts_o.arith_done = ar_done;
    sts_o.out_free   = !out_valid_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ring bookkeeping checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("ring count above depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SW'(head_q) < SW'(SAMPLE_DEPTH))
    else $error("ring head out of range");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmd == CMD_CLEAR |=> count_q == '0 && gap_q == '0)
    else $error("clear left entries behind");

  a_arrive_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmd == CMD_ARRIVE && !full |=> count_q == $past(count_q) + CW'(1))
    else $error("arrival did not add an entry");

endmodule

[rtl/core/wmrm_ctrl.sv]
// controller: sequences arrival, clear and the query walk and arithmetic
`timescale 1ns / 1ps
module wmrm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_op_i,
  output logic                in_ready_o,
  output wmrm_pkg::ctrl_cmd_t cmd_o,
  input  wmrm_pkg::ctrl_sts_t sts_i
);
  import wmrm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_CLEAR,
    ST_PRUNE_RD,
    ST_PRUNE_TEST,
    ST_WALK_START,
    ST_WALK_RD,
    ST_WALK_ACC,
    ST_ARITH_GO,
    ST_ARITH_WAIT,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  sel_e   sel_q, sel_d;

  // next state and command
  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    cmd_o.cmd  = CMD_NONE;
    cmd_o.sel  = sel_q;
    in_ready_o = state_q == ST_IDLE;
    case (state_q)
      ST_IDLE: begin
        sel_d = SEL_AVG_MUL;
        if (in_valid_i) begin
          cmd_o.cmd = CMD_LOAD;
          case (op_e'(in_op_i))
            OP_ARRIVE: state_d = ST_ARRIVE;
            OP_QUERY:  state_d = ST_PRUNE_RD;
            OP_CLEAR:  state_d = ST_CLEAR;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_ARRIVE: begin
        cmd_o.cmd = CMD_ARRIVE;
        state_d   = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd_o.cmd = CMD_CLEAR;
        state_d   = ST_IDLE;
      end
      ST_PRUNE_RD: begin
        if (sts_i.ring_empty) begin
          state_d = ST_WALK_START;
        end else begin
          cmd_o.cmd = CMD_PRUNE_READ;
          state_d   = ST_PRUNE_TEST;
        end
      end
      ST_PRUNE_TEST: begin
        cmd_o.cmd = CMD_PRUNE_TEST;
        state_d   = sts_i.prune_old ? ST_PRUNE_RD : ST_WALK_START;
      end
      ST_WALK_START: begin
        cmd_o.cmd = CMD_WALK_START;
        state_d   = sts_i.ring_empty ? ST_ARITH_GO : ST_WALK_RD;
      end
      ST_WALK_RD: begin
        cmd_o.cmd = CMD_WALK_READ;
        state_d   = ST_WALK_ACC;
      end
      ST_WALK_ACC: begin
        cmd_o.cmd = CMD_WALK_ACC;
        state_d   = sts_i.walk_last ? ST_ARITH_GO : ST_WALK_RD;
      end
      ST_ARITH_GO: begin
        cmd_o.cmd = CMD_ARITH_START;
        state_d   = ST_ARITH_WAIT;
      end
      ST_ARITH_WAIT: begin
        if (sts_i.arith_done) begin
          cmd_o.cmd = CMD_ARITH_STORE;
          state_d   = ST_ARITH_GO;
          case (sel_q)
            SEL_AVG_MUL:  sel_d = SEL_AVG_DIV;
            SEL_AVG_DIV:  sel_d = SEL_RMIN_DIV;
            SEL_RMIN_DIV: sel_d = SEL_RMAX_DIV;
            SEL_RMAX_DIV: sel_d = SEL_BW_MUL;
            SEL_BW_MUL:   sel_d = SEL_BW_DIV;
            SEL_BW_DIV:   sel_d = SEL_LAVG_DIV;
            SEL_LAVG_DIV: sel_d = SEL_DROP_L;
            SEL_DROP_L:   sel_d = SEL_DROP_R;
            default: begin
              sel_d   = SEL_AVG_MUL;
              state_d = ST_OUT;
            end
          endcase
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.cmd = CMD_OUT;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and step registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= SEL_AVG_MUL;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

endmodule

[rtl/core/windowed_message_rate_monitor_top.sv]
// top level of the windowed message rate monitor
//
//   channel   direction  handshake                payload
//   s_axis    in         s_axis_tvalid/tready     tdata 128 b, tuser 2 b (request kind)
//   m_axis    out        m_axis_tvalid/tready     tdata 408 b (statistics of one query)
//   cfg       in         cfg_valid_i/cfg_ready_o  cfg_addr_i 1 b, cfg_data_i 16 b
//
// a query prunes old entries, walks the remaining ones through the one-read-port ring,
// then uses the 64-step shared divider five times and four 4-step multiplies. reset
// empties the ring and loads window 1000 ms and factor 512; the ring memory itself is
// not cleared. a query result waits in the output register; arrivals and clears go on
// meanwhile, a further query is taken but then holds s_axis_tready low until that
// register is free.
`timescale 1ns / 1ps
module windowed_message_rate_monitor_top #(
  parameter int unsigned SAMPLE_DEPTH = wmrm_pkg::DEF_SAMPLE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // timestamp_ns [62:0], message_bytes [94:63], latency [126:95], zero [127]
  input  logic [127:0] s_axis_tdata,
  // operation [1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rate_avg_hz [31:0], rate_min_hz [63:32], rate_max_hz [95:64],
  // bandwidth_bps [143:96], lat_avg_us [175:144], lat_min_us [207:176],
  // lat_max_us [239:208], message_total [287:240], byte_total [343:288],
  // drop_flag [344], gap_ns [407:345]
  output logic [407:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_addr_i,
  input  logic [15:0]  cfg_data_i
);
  import wmrm_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_ready;

  // registers are written whenever requested
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = in_ready;

  wmrm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_op_i   (s_axis_tuser),
    .in_ready_o(in_ready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  wmrm_dp #(
    .SAMPLE_DEPTH(SAMPLE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .in_ts_i    (s_axis_tdata[62:0]),
    .in_bytes_i (s_axis_tdata[94:63]),
    .in_lat_i   (s_axis_tdata[126:95]),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata)
  );

endmodule

[bench/wmrm_checker.sv]
// checker for the message rate monitor: predicts query statistics and compares results
`timescale 1ns / 1ps
module wmrm_checker
  import wmrm_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_SAMPLE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [407:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_o,
  input  logic         cfg_addr_i,
  input  logic [15:0]  cfg_data_i,
  output int           fail_count_o,
  output int           pending_o
);

  localparam logic [63:0] MAX32 = 64'hFFFF_FFFF;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [55:0] MAX56 = 56'hFF_FFFF_FFFF_FFFF;
  localparam int          EXP_DEPTH = 16;

  // one query result, highest field first
  typedef struct packed {
    logic [62:0] gap_ns;
    logic        drop_flag;
    logic [55:0] byte_total;
    logic [47:0] message_total;
    logic [31:0] lat_max_us;
    logic [31:0] lat_min_us;
    logic [31:0] lat_avg_us;
    logic [47:0] bandwidth_bps;
    logic [31:0] rate_max_hz;
    logic [31:0] rate_min_hz;
    logic [31:0] rate_avg_hz;
  } stats_t;

  // mirrored monitor state
  logic [63:0] arrival_ts [DEPTH];
  logic [31:0] arrival_sz [DEPTH];
  logic [31:0] arrival_lat[DEPTH];
  int unsigned head;
  int unsigned count;
  logic [63:0] last_arrival;
  bit          last_valid;
  logic [63:0] last_gap;
  logic [47:0] msg_seen;
  logic [55:0] byte_seen;
  logic [15:0] window_reg;
  logic [15:0] factor_reg;

  // expected results in order of their queries
  stats_t stats_expected[EXP_DEPTH];
  int     exp_wr;
  int     exp_rd;
  int     fails;
  int     mismatches;

  assign fail_count_o = fails;
  assign pending_o    = exp_wr - exp_rd;

  function automatic int unsigned slot(int unsigned k);
    return (head + k) % DEPTH;
  endfunction

  function automatic logic [63:0] sat32(logic [63:0] v);
    return (v > MAX32) ? MAX32 : v;
  endfunction

  // arrival updates gap, ring and totals
  task automatic apply_arrival(logic [62:0] t, logic [31:0] nb, logic [31:0] lat);
    int unsigned w;
    logic [63:0] ts;
    ts = {1'b0, t};
    last_gap = (last_valid && ts > last_arrival) ? ts - last_arrival : 64'd0;
    if (count >= DEPTH) begin
      head  = slot(1);
      count = DEPTH - 1;
    end
    w = slot(count);
    arrival_ts[w]  = ts;
    arrival_sz[w]  = nb;
    arrival_lat[w] = lat;
    count++;
    last_arrival = ts;
    last_valid   = 1'b1;
    if (msg_seen != MAX48) msg_seen++;
    byte_seen = (MAX56 - byte_seen < {24'd0, nb}) ? MAX56 : byte_seen + nb;
  endtask

  task automatic clear_state();
    head = 0;
    count = 0;
    last_arrival = '0;
    last_valid = 1'b0;
    last_gap = '0;
    msg_seen = '0;
    byte_seen = '0;
  endtask

  // prune old entries, then work out every statistic of the window
  task automatic compute_stats(logic [62:0] t, output stats_t r);
    logic [63:0] now, wms, factor, win_ns, avg, rmin, rmax, bw, span;
    logic [63:0] gmin, gmax, bsum, lsum, lcnt, a, b, g, lavg, m, s;
    logic [31:0] lmin, lmax, l;
    logic [127:0] lhs, rhs;
    int unsigned n;
    bit drop;
    now = {1'b0, t};
    wms = (window_reg == 0) ? 64'd100 : {48'd0, window_reg};
    factor = (factor_reg > 16'd256) ? {48'd0, factor_reg} : 64'd512;
    win_ns = wms * 64'd1000000;
    avg = 0; rmin = 0; rmax = 0; bw = 0; span = 0;
    gmin = 0; gmax = 0; bsum = 0; lsum = 0; lcnt = 0; lmin = 0; lmax = 0;
    drop = 1'b0;
    while (count > 0 && arrival_ts[slot(0)] + win_ns < now) begin
      head = slot(1);
      count--;
    end
    n = count;
    if (n == 1) begin
      avg = 256; rmin = 256; rmax = 256;
    end else if (n >= 2) begin
      a = arrival_ts[slot(0)];
      b = arrival_ts[slot(n - 1)];
      if (b > a) begin
        span = b - a;
        avg = sat32(64'(n - 1) * NS_Q8 / span);
      end
      for (int unsigned k = 1; k < n; k++) begin
        a = arrival_ts[slot(k - 1)];
        b = arrival_ts[slot(k)];
        if (b > a) begin
          g = b - a;
          if (gmin == 0 || g < gmin) gmin = g;
          if (g > gmax) gmax = g;
        end
      end
      if (gmax != 0) begin
        rmin = sat32(NS_Q8 / gmax);
        rmax = sat32(NS_Q8 / gmin);
      end
    end
    for (int unsigned k = 0; k < n; k++) begin
      l = arrival_lat[slot(k)];
      bsum += arrival_sz[slot(k)];
      if (!l[31]) begin
        if (lcnt == 0 || l < lmin) lmin = l;
        if (lcnt == 0 || l > lmax) lmax = l;
        lsum += l;
        lcnt++;
      end
    end
    if (n > 0) begin
      bw = bsum * 64'd1000 / wms;
      if (bw > {16'd0, MAX48}) bw = {16'd0, MAX48};
    end
    lavg = (lcnt > 0) ? lsum / lcnt : MAX32;
    if (lcnt == 0) begin
      lmin = '1;
      lmax = '1;
    end
    // drop test in full width, one entry expects a one second gap
    if (last_gap > 0 && (n == 1 || span > 0)) begin
      m = (n == 1) ? 64'd256 : 64'(n - 1) * 64'd256;
      s = (n == 1) ? NS_PER_S : span;
      lhs = {64'd0, last_gap} * {64'd0, m};
      rhs = {64'd0, factor} * {64'd0, s};
      drop = lhs > rhs;
    end
    r.rate_avg_hz   = avg[31:0];
    r.rate_min_hz   = rmin[31:0];
    r.rate_max_hz   = rmax[31:0];
    r.bandwidth_bps = bw[47:0];
    r.lat_avg_us    = lavg[31:0];
    r.lat_min_us    = lmin;
    r.lat_max_us    = lmax;
    r.message_total = msg_seen;
    r.byte_total    = byte_seen;
    r.drop_flag     = drop;
    r.gap_ns        = last_gap[62:0];
  endtask

  task automatic check_field(string nm, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      fails++;
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch %s: expected %0h, got %0h", $realtime, nm, exp_v, act_v);
    end
  endtask

  // watch the channels on each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    stats_t got, want;
    if (!rst_ni) begin
      clear_state();
      window_reg = WINDOW_RST;
      factor_reg = FACTOR_RST;
      exp_wr = 0;
      exp_rd = 0;
      fails = 0;
      mismatches = 0;
    end else begin
      // result side
      if (m_axis_tvalid && m_axis_tready) begin
        got = stats_t'(m_axis_tdata);
        if (exp_wr == exp_rd) begin
          fails++;
          $display("%0t result with no query waiting", $realtime);
        end else begin
          want = stats_expected[exp_rd % EXP_DEPTH];
          exp_rd++;
          check_field("rate_avg_hz", 64'(want.rate_avg_hz), 64'(got.rate_avg_hz));
          check_field("rate_min_hz", 64'(want.rate_min_hz), 64'(got.rate_min_hz));
          check_field("rate_max_hz", 64'(want.rate_max_hz), 64'(got.rate_max_hz));
          check_field("bandwidth_bps", 64'(want.bandwidth_bps), 64'(got.bandwidth_bps));
          check_field("lat_avg_us", 64'(want.lat_avg_us), 64'(got.lat_avg_us));
          check_field("lat_min_us", 64'(want.lat_min_us), 64'(got.lat_min_us));
          check_field("lat_max_us", 64'(want.lat_max_us), 64'(got.lat_max_us));
          check_field("message_total", 64'(want.message_total), 64'(got.message_total));
          check_field("byte_total", 64'(want.byte_total), 64'(got.byte_total));
          check_field("drop_flag", 64'(want.drop_flag), 64'(got.drop_flag));
          check_field("gap_ns", 64'(want.gap_ns), 64'(got.gap_ns));
        end
      end
      // request side
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          OP_ARRIVE: apply_arrival(s_axis_tdata[62:0], s_axis_tdata[94:63],
                                   s_axis_tdata[126:95]);
          OP_QUERY: begin
            compute_stats(s_axis_tdata[62:0], want);
            stats_expected[exp_wr % EXP_DEPTH] = want;
            exp_wr++;
          end
          OP_CLEAR: clear_state();
          default: ;
        endcase
      end
      // register writes
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_addr_i == CFG_WINDOW) window_reg = cfg_data_i;
        else factor_reg = cfg_data_i;
      end
    end
  end

endmodule

[bench/tb.sv]
// testbench top: drives requests, register writes and result stalls of the rate monitor
`timescale 1ns / 1ps
module tb;
  import wmrm_pkg::*;

  localparam logic [1:0]  OP_IGNORED = 2'd3;
  localparam logic [63:0] TS_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] LAT_NONE   = 32'hFFFF_FFFF;
  localparam int          WATCH_LIMIT = 20000;
  localparam int          HOLD_CYCLES = 3000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = OP_ARRIVE;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [407:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic         cfg_addr_i = CFG_WINDOW;
  logic [15:0]  cfg_data_i = '0;
  int           fail_count;
  int           pending;

  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;
  logic [63:0] win_ns;
  logic [63:0] cur_ts;

  windowed_message_rate_monitor_top dut (.*);

  wmrm_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i, .cfg_ready_o,
    .cfg_addr_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // idle length: mostly none, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    int idle_cycles;
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // result side stalls, with one long hold-off on request
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          m_axis_tready = 1'b0;
          repeat (n) @(negedge clk_i);
        end
        m_axis_tready = 1'b1;
        repeat ($urandom_range(0, 8)) @(negedge clk_i);
      end
    end
  end

  task automatic send_req(logic [1:0] op, logic [63:0] ts, logic [31:0] nb,
                          logic [31:0] lat);
    int unsigned g;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {1'b0, lat, nb, ts[62:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // register write once the monitor has drained
  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_addr_i  = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_regs(logic [15:0] wnd, logic [15:0] fac);
    write_reg(CFG_WINDOW, wnd);
    write_reg(CFG_FACTOR, fac);
    win_ns = ((wnd == 0) ? 64'd100 : 64'(wnd)) * 64'd1000000;
  endtask

  function automatic logic [31:0] pick_latency();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 100000);
    if (r < 85) return $urandom;
    return LAT_NONE;
  endfunction

  function automatic logic [31:0] pick_bytes();
    return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1500);
  endfunction

  function automatic logic [63:0] clamp_ts(logic [63:0] v);
    return (v > TS_MAX) ? TS_MAX : v;
  endfunction

  // random traffic: mostly rising arrival times, queries, a few clears and junk
  task automatic random_traffic(int unsigned items);
    int unsigned r;
    logic [63:0] step, now;
    for (int unsigned i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      if (i % 100 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (r < 62) begin
        r = $urandom_range(0, 9);
        step = rand64() % (win_ns >> $urandom_range(1, 8)) + 1;
        if (r == 0) step = 0;
        if (r == 1) cur_ts = (cur_ts > step) ? cur_ts - step : 64'd0;
        else cur_ts = clamp_ts(cur_ts + step);
        send_req(OP_ARRIVE, cur_ts, pick_bytes(), pick_latency());
      end else if (r < 93) begin
        case ($urandom_range(0, 4))
          0: now = cur_ts;
          1: now = clamp_ts(cur_ts + win_ns * $urandom_range(1, 3));
          2: now = (cur_ts > win_ns) ? cur_ts - win_ns : 64'd0;
          default: now = clamp_ts(cur_ts + rand64() % win_ns);
        endcase
        send_req(OP_QUERY, now, $urandom, $urandom);
      end else if (r < 96) begin
        send_req(OP_CLEAR, rand64(), $urandom, $urandom);
      end else begin
        send_req(OP_IGNORED, rand64(), $urandom, $urandom);
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic phase(logic [15:0] wnd, logic [15:0] fac, int unsigned items);
    set_regs(wnd, fac);
    cur_ts = rand64() & TS_MAX;
    if (cur_ts > TS_MAX - (64'd1 << 56)) cur_ts = cur_ts - (64'd1 << 56);
    random_traffic(items);
  endtask

  initial begin
    win_ns = 64'd1000000000;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty window, equal and earlier times, field extremes
    send_req(OP_QUERY, 64'd0, 32'd0, 32'd0);
    send_req(OP_ARRIVE, 64'd0, 32'd0, LAT_NONE);
    send_req(OP_QUERY, 64'd0, 32'd0, 32'd0);
    send_req(OP_ARRIVE, 64'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_req(OP_ARRIVE, 64'd500000000, 32'd1, 32'd0);
    send_req(OP_ARRIVE, 64'd400000000, 32'd100, 32'h8000_0000);
    send_req(OP_QUERY, 64'd500000000, 32'd0, 32'd0);
    send_req(OP_IGNORED, TS_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_ARRIVE, 64'd3000000000, 32'd64, 32'd5);
    send_req(OP_QUERY, 64'd3000000000, 32'd0, 32'd0);
    send_req(OP_QUERY, 64'd3500000000, 32'd0, 32'd0);
    send_req(OP_CLEAR, 64'd0, 32'd0, 32'd0);
    send_req(OP_QUERY, 64'd0, 32'd0, 32'd0);
    send_req(OP_ARRIVE, TS_MAX - 10, 32'hFFFF_FFFF, 32'd9);
    send_req(OP_ARRIVE, TS_MAX, 32'hFFFF_FFFF, 32'd3);
    send_req(OP_QUERY, TS_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_CLEAR, TS_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_QUERY, TS_MAX, 32'd0, 32'd0);

    // random phases over several register settings
    phase(16'd1000, 16'd512, 300);
    phase(16'd1, 16'd257, 300);
    phase(16'd0, 16'd0, 250);
    phase(16'd5, 16'd256, 250);
    phase(16'd20, 16'd65535, 250);

    // wide window: fill past the ring depth, then stall results while queries queue up
    set_regs(16'd65535, 16'd1000);
    cur_ts = 64'd1000;
    no_idle = 1'b1;
    for (int i = 0; i < 270; i++) begin
      cur_ts = cur_ts + $urandom_range(0, 2000);
      send_req(OP_ARRIVE, cur_ts, pick_bytes(), pick_latency());
    end
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++)
      send_req(OP_QUERY, cur_ts + i, 32'd0, 32'd0);
    no_idle = 1'b0;
    random_traffic(250);

    phase(16'($urandom_range(1, 65535)), 16'($urandom_range(257, 65535)), 150);

    // drain and settle
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
